// ===== sv/fdcr_pkg.sv =====
package fdcr_pkg;

	// bus access codes
	localparam logic [3:0] ACC_RD_STATUS  = 4'd0;
	localparam logic [3:0] ACC_RD_DATA    = 4'd1;
	localparam logic [3:0] ACC_RD_AUX     = 4'd2;
	localparam logic [3:0] ACC_RD_TRACK   = 4'd3;
	localparam logic [3:0] ACC_RD_SECTOR  = 4'd4;
	localparam logic [3:0] ACC_WR_COMMAND = 4'd5;
	localparam logic [3:0] ACC_WR_DATA    = 4'd6;
	localparam logic [3:0] ACC_WR_CONTROL = 4'd7;
	localparam logic [3:0] ACC_WR_TRACK   = 4'd8;
	localparam logic [3:0] ACC_WR_SECTOR  = 4'd9;

	// command nibbles
	localparam logic [3:0] CMD_RESTORE   = 4'h0;
	localparam logic [3:0] CMD_SEEK      = 4'h1;
	localparam logic [3:0] CMD_FORCE_INT = 4'hD;

	// drive select nibble of a control write that picks the drive
	localparam logic [3:0] CTRL_DRIVE0 = 4'h1;

	// configuration register indexes
	localparam logic [3:0] CFG_DISK_PRESENT = 4'd0;
	localparam logic [3:0] CFG_TRACK_LIMIT  = 4'd1;

	// status and aux status bytes
	localparam logic [7:0] ST_TRACK0   = 8'h04;
	localparam logic [7:0] ST_SEEK_OK  = 8'h20;
	localparam logic [7:0] ST_SEEK_ERR = 8'h38;
	localparam logic [7:0] ST_UNKNOWN  = 8'h5C;
	localparam logic [7:0] ST_MOTOR    = 8'h80;
	localparam logic [7:0] AUX_IRQ_ON  = 8'h3E;
	localparam logic [7:0] AUX_IRQ_OFF = 8'h3C;
	localparam logic [7:0] AUX_NOCHG   = 8'h40;

	localparam logic [7:0] TRACK_LIMIT_RESET = 8'd82;

	typedef struct packed {
		logic [3:0] cmd;
		logic [7:0] value;
	} access_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       irq;
		logic       side;
	} result_t;

endpackage

// ===== sv/floppy_controller_registers_core.sv =====
// Register file of a floppy disk controller with its drive-control latch.
// Input channel (in_valid/in_ready): one bus access per item, cmd selects the
// register and the direction, write_value is the byte for writes.
// Output channel (out_valid/out_ready): one result item per access, carrying
// the byte read (0 for writes), the interrupt line and the selected side as
// they stand after that access.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is
// disk present, index 1 the track limit for seeks; other indexes are ignored.
// It is always ready; write it only while no access is in flight.
// An accepted item is registered in the access stage, and its result then
// moves into the output register, from which the receiver takes it.
// Throughput is one item per cycle while the receiver does not stall; the
// single access stage plus the output register sustain that rate.
// When the receiver stalls, the result holds in the output register and one
// more item waits in the access stage; in_ready drops only when both are full.
// Reset clears both stages and returns the registers to their power-on values:
// status shows track zero, no disk selected, no interrupt, track limit 82.
module floppy_controller_registers_core
	import fdcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] cmd,
	input  logic [7:0] write_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_value,
	output logic       irq_active,
	output logic       head_side,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic    acc_valid_s1;
	access_t acc_s1;
	logic    out_free;
	logic    advance;

	logic       disk_present_q;
	logic [7:0] track_limit_q;
	logic [7:0] track_q;
	logic [7:0] sector_q;
	logic [7:0] status_q;
	logic [7:0] data_q;
	logic       irq_q;
	logic       drive_sel_q;
	logic       side_q;
	logic       not_ins_q;

	logic [7:0] track_d;
	logic [7:0] sector_d;
	logic [7:0] status_d;
	logic [7:0] data_d;
	logic       irq_d;
	logic       drive_sel_d;
	logic       side_d;
	logic       not_ins_d;
	logic [7:0] rd;
	logic       seek_ok;
	logic [7:0] seek_track;
	result_t    res_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;
	assign advance   = acc_valid_s1 && out_free;
	assign in_ready  = !acc_valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_present_q <= 1'b0;
			track_limit_q  <= TRACK_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DISK_PRESENT: disk_present_q <= cfg_data[0];
				CFG_TRACK_LIMIT:  track_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			acc_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			acc_s1.cmd   <= cmd;
			acc_s1.value <= write_value;
		end
	end

	assign seek_ok    = (data_q < track_limit_q) && drive_sel_q;
	assign seek_track = seek_ok ? data_q : track_q;

	always_comb begin
		track_d     = track_q;
		sector_d    = sector_q;
		status_d    = status_q;
		data_d      = data_q;
		irq_d       = irq_q;
		drive_sel_d = drive_sel_q;
		side_d      = side_q;
		not_ins_d   = not_ins_q;
		rd          = 8'h00;
		case (acc_s1.cmd)
			ACC_RD_STATUS: begin
				irq_d = 1'b0;
				rd    = ST_MOTOR | status_q;
			end
			ACC_RD_DATA:   rd = data_q;
			ACC_RD_AUX:    rd = (irq_q ? AUX_IRQ_ON : AUX_IRQ_OFF) | AUX_NOCHG
				| {7'd0, not_ins_q};
			ACC_RD_TRACK:  rd = track_q;
			ACC_RD_SECTOR: rd = sector_q;
			ACC_WR_COMMAND: begin
				case (acc_s1.value[7:4])
					CMD_RESTORE: begin
						irq_d = 1'b1;
						if (drive_sel_q) begin
							status_d = ST_TRACK0 | ST_SEEK_OK;
							track_d  = 8'h00;
						end else begin
							status_d = ST_SEEK_ERR | ST_TRACK0;
						end
					end
					CMD_SEEK: begin
						irq_d    = 1'b1;
						track_d  = seek_track;
						status_d = (seek_ok ? ST_SEEK_OK : ST_SEEK_ERR)
							| ((seek_track == 8'h00) ? ST_TRACK0 : 8'h00);
					end
					CMD_FORCE_INT: begin
						// interrupt only when some condition bit is set
						irq_d    = |acc_s1.value[3:0];
						status_d = (track_q == 8'h00) ? ST_TRACK0 : 8'h00;
					end
					default: begin
						irq_d    = 1'b1;
						status_d = ST_UNKNOWN;
					end
				endcase
			end
			ACC_WR_DATA: data_d = acc_s1.value;
			ACC_WR_CONTROL: begin
				drive_sel_d = disk_present_q && (acc_s1.value[3:0] == CTRL_DRIVE0);
				side_d      = acc_s1.value[4];
				not_ins_d   = !drive_sel_d;
			end
			ACC_WR_TRACK:  track_d  = acc_s1.value;
			ACC_WR_SECTOR: sector_d = acc_s1.value;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q     <= 8'h00;
			sector_q    <= 8'h00;
			status_q    <= ST_TRACK0;
			data_q      <= 8'h00;
			irq_q       <= 1'b0;
			drive_sel_q <= 1'b0;
			side_q      <= 1'b0;
			not_ins_q   <= 1'b1;
		end else if (advance) begin
			track_q     <= track_d;
			sector_q    <= sector_d;
			status_q    <= status_d;
			data_q      <= data_d;
			irq_q       <= irq_d;
			drive_sel_q <= drive_sel_d;
			side_q      <= side_d;
			not_ins_q   <= not_ins_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= acc_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.read_value <= rd;
			res_q.irq        <= irq_d;
			res_q.side       <= side_d;
		end
	end

	assign read_value = res_q.read_value;
	assign irq_active = res_q.irq;
	assign head_side  = res_q.side;

	a_not_ins_tracks_sel: assert property (@(posedge clk) disable iff (!arst_n)
		not_ins_q == !drive_sel_q)
		else $error("not-inserted flag out of step with drive select");

	a_status_read_clears_irq: assert property (@(posedge clk) disable iff (!arst_n)
		advance && acc_s1.cmd == ACC_RD_STATUS |=> !irq_q && !irq_active)
		else $error("status read left the interrupt set");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> irq_active == irq_q && head_side == side_q)
		else $error("result item disagrees with register state");

	a_restore_homes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && acc_s1.cmd == ACC_WR_COMMAND && acc_s1.value[7:4] == CMD_RESTORE
		&& drive_sel_q |=> track_q == 8'h00 && status_q[2])
		else $error("restore did not reach track zero");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!acc_valid_s1 |-> in_ready)
		else $error("input stalled with empty access stage");

endmodule
